>>> rtl/skh_pkg.sv
// Shared codes and types for the string-keyed bucket hash table.
// No dependencies; used by every module of the block.
`default_nettype none
package skh_pkg;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;

  // Key summary handed from the byte gatherer to the table engine.
  // Widths cover the largest supported key length and bucket count.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] length;
    logic [9:0] bucket;
    logic       too_long;
  } key_info_t;

endpackage
`default_nettype wire

>>> rtl/skh_gather.sv
// Key byte gatherer: key buffer, running length and bucket hash.
// Depends on skh_pkg.
`default_nettype none
module skh_gather #(
  parameter int BUCKETS     = 33,
  parameter int MAX_KEY_LEN = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic [1:0]          action,
  input  wire logic [6:0]          key_char,
  input  wire logic                last,
  input  wire logic [((MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1)-1:0] kb_ra,
  output logic      [6:0]          kb_q,
  output logic                     start,
  output skh_pkg::key_info_t       info
);

  localparam int LW = $clog2(MAX_KEY_LEN + 1);
  localparam int IW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int RW = $clog2(BUCKETS + 128) + 9;

  logic [6:0]    kb_mem [MAX_KEY_LEN];
  logic [LW-1:0] len;
  logic [LW-1:0] len_next;
  logic [BW-1:0] hash;
  logic [BW-1:0] hash_next;
  logic          too_long;
  logic          can_store;
  logic [RW-1:0] red;

  assign can_store = !too_long && (len < LW'(MAX_KEY_LEN));
  assign len_next  = can_store ? len + LW'(1) : len;

  // Sum stays below BUCKETS + 128, so eight conditional subtractions of
  // shifted bucket counts reduce it fully.
  always_comb begin
    red = RW'(hash) + RW'(key_char);
    for (int k = 7; k >= 0; k--) begin
      if (red >= (RW'(BUCKETS) << k)) begin
        red = red - (RW'(BUCKETS) << k);
      end
    end
    hash_next = BW'(red);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      hash     <= '0;
      too_long <= 1'b0;
      start    <= 1'b0;
    end else begin
      start <= 1'b0;
      if (accept) begin
        if (last) begin
          len           <= '0;
          hash          <= '0;
          too_long      <= 1'b0;
          start         <= 1'b1;
          info.action   <= action;
          info.length   <= 8'(len_next);
          info.bucket   <= 10'(hash_next);
          info.too_long <= !can_store;
        end else begin
          len      <= len_next;
          hash     <= hash_next;
          too_long <= !can_store;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && can_store) begin
      kb_mem[len[IW-1:0]] <= key_char;
    end
    kb_q <= kb_mem[kb_ra];
  end

endmodule
`default_nettype wire

>>> rtl/skh_engine.sv
// Table engine: slot memories and the sequencer that walks one bucket.
// Depends on skh_pkg; reads the key buffer held in skh_gather.
`default_nettype none
module skh_engine #(
  parameter int BUCKETS     = 33,
  parameter int SLOTS       = 6,
  parameter int MAX_KEY_LEN = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata,
  input  wire logic                start,
  input  wire skh_pkg::key_info_t  info,
  output logic [((MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1)-1:0] kb_ra,
  input  wire logic [6:0]          kb_q,
  output logic                     idle,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               status,
  output logic [5:0]               bucket
);

  localparam int LW    = $clog2(MAX_KEY_LEN + 1);
  localparam int IW    = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int ROWS  = BUCKETS * SLOTS;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DEPTH = ROWS * MAX_KEY_LEN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SCW   = $clog2(SLOTS + 1);

  typedef enum logic [13:0] {
    IDLE   = 14'b00000000000001,
    F_LRD  = 14'b00000000000010,
    F_LCHK = 14'b00000000000100,
    F_CRD  = 14'b00000000001000,
    F_CCHK = 14'b00000000010000,
    E_LRD  = 14'b00000000100000,
    E_LCHK = 14'b00000001000000,
    W_RD   = 14'b00000010000000,
    W_WR   = 14'b00000100000000,
    D_LRD  = 14'b00001000000000,
    D_LCHK = 14'b00010000000000,
    D_CRD  = 14'b00100000000000,
    D_CWR  = 14'b01000000000000,
    D_CLR  = 14'b10000000000000
  } state_t;

  state_t          state;
  logic [1:0]      op;
  logic            reject;
  logic [LW-1:0]   klen;
  logic [LW-1:0]   slen;
  logic [BW-1:0]   bkt;
  logic [RW-1:0]   row;
  logic [SCW-1:0]  s;
  logic [LW-1:0]   i;
  logic            src;

  logic [LW-1:0]   len_mem [ROWS];
  logic [ROWS-1:0] len_vld;
  logic [6:0]      chr_mem [DEPTH];
  logic [LW-1:0]   len_q;
  logic            vld_q;
  logic [6:0]      chr_q;

  logic [RW-1:0]   rd_row;
  logic [AW-1:0]   chr_ra;
  logic [AW-1:0]   chr_wa;
  logic [LW-1:0]   cur_len;
  logic            last_slot;
  logic            last_char;
  logic            last_copy;
  logic            find_hit;
  logic            find_miss;

  // While shifting down on delete, reads come from the slot above.
  assign rd_row    = src ? row + RW'(1) : row;
  assign chr_ra    = AW'(32'(rd_row) * MAX_KEY_LEN + 32'(i));
  assign chr_wa    = AW'(32'(row) * MAX_KEY_LEN + 32'(i));
  assign kb_ra     = i[IW-1:0];
  assign cur_len   = vld_q ? len_q : '0;
  assign last_slot = (s == SCW'(SLOTS - 1));
  assign last_char = ((i + LW'(1)) == klen);
  assign last_copy = ((i + LW'(1)) == slen);
  assign find_hit  = (state == F_CCHK) && (chr_q == kb_q) && last_char;
  assign find_miss = last_slot && (((state == F_LCHK) && (cur_len != klen)) ||
                                   ((state == F_CCHK) && (chr_q != kb_q)));
  assign idle      = (state == IDLE) && !start;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      reject    <= 1'b0;
      len_vld   <= '0;
      src       <= 1'b0;
    end else begin
      if (cfg_we) begin
        reject <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (start) begin
            op   <= info.action;
            klen <= LW'(info.length);
            bkt  <= BW'(info.bucket);
            row  <= RW'(32'(BW'(info.bucket)) * SLOTS);
            s    <= '0;
            i    <= '0;
            src  <= 1'b0;
            if (info.too_long) begin
              out_valid <= 1'b1;
              status    <= skh_pkg::ST_TOO_LONG;
              bucket    <= 6'(info.bucket);
            end else if (info.action == skh_pkg::ACT_INSERT && !reject) begin
              state <= E_LRD;
            end else begin
              state <= F_LRD;
            end
          end
        end
        F_LRD: state <= F_LCHK;
        F_LCHK: begin
          if (cur_len == klen) begin
            i     <= '0;
            state <= F_CRD;
          end else if (!last_slot) begin
            s     <= s + SCW'(1);
            row   <= row + RW'(1);
            state <= F_LRD;
          end
        end
        F_CRD: state <= F_CCHK;
        F_CCHK: begin
          if (chr_q != kb_q) begin
            if (!last_slot) begin
              s     <= s + SCW'(1);
              row   <= row + RW'(1);
              state <= F_LRD;
            end
          end else if (!last_char) begin
            i     <= i + LW'(1);
            state <= F_CRD;
          end
        end
        E_LRD: state <= E_LCHK;
        E_LCHK: begin
          if (cur_len == '0) begin
            i     <= '0;
            state <= W_RD;
          end else if (last_slot) begin
            out_valid <= 1'b1;
            status    <= skh_pkg::ST_FULL;
            bucket    <= 6'(bkt);
            state     <= IDLE;
          end else begin
            s     <= s + SCW'(1);
            row   <= row + RW'(1);
            state <= E_LRD;
          end
        end
        W_RD: state <= W_WR;
        W_WR: begin
          if (last_char) begin
            len_vld[row] <= 1'b1;
            out_valid    <= 1'b1;
            status       <= skh_pkg::ST_OK;
            bucket       <= 6'(bkt);
            state        <= IDLE;
          end else begin
            i     <= i + LW'(1);
            state <= W_RD;
          end
        end
        D_LRD: state <= D_LCHK;
        D_LCHK: begin
          len_vld[row] <= vld_q;
          slen         <= len_q;
          i            <= '0;
          if (!vld_q || len_q == '0) begin
            // Everything above an empty slot is empty already.
            src       <= 1'b0;
            out_valid <= 1'b1;
            status    <= skh_pkg::ST_OK;
            bucket    <= 6'(bkt);
            state     <= IDLE;
          end else begin
            state <= D_CRD;
          end
        end
        D_CRD: state <= D_CWR;
        D_CWR: begin
          if (last_copy) begin
            i   <= '0;
            s   <= s + SCW'(1);
            row <= row + RW'(1);
            if ((s + SCW'(1)) == SCW'(SLOTS - 1)) begin
              src   <= 1'b0;
              state <= D_CLR;
            end else begin
              state <= D_LRD;
            end
          end else begin
            i     <= i + LW'(1);
            state <= D_CRD;
          end
        end
        D_CLR: begin
          len_vld[row] <= 1'b0;
          out_valid    <= 1'b1;
          status       <= skh_pkg::ST_OK;
          bucket       <= 6'(bkt);
          state        <= IDLE;
        end
        default: state <= IDLE;
      endcase

      if (find_hit) begin
        case (op)
          skh_pkg::ACT_INSERT: begin
            out_valid <= 1'b1;
            status    <= skh_pkg::ST_DUPLICATE;
            bucket    <= 6'(bkt);
            state     <= IDLE;
          end
          skh_pkg::ACT_DELETE: begin
            if (last_slot) begin
              state <= D_CLR;
            end else begin
              src   <= 1'b1;
              state <= D_LRD;
            end
          end
          default: begin
            out_valid <= 1'b1;
            status    <= skh_pkg::ST_OK;
            bucket    <= 6'(bkt);
            state     <= IDLE;
          end
        endcase
      end else if (find_miss) begin
        if (op == skh_pkg::ACT_INSERT) begin
          s     <= '0;
          row   <= RW'(32'(bkt) * SLOTS);
          state <= E_LRD;
        end else begin
          out_valid <= 1'b1;
          status    <= skh_pkg::ST_NOT_FOUND;
          bucket    <= 6'(bkt);
          state     <= IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == W_WR) begin
      chr_mem[chr_wa] <= kb_q;
      if (last_char) begin
        len_mem[row] <= klen;
      end
    end else if (state == D_CWR) begin
      chr_mem[chr_wa] <= chr_q;
    end else if (state == D_LCHK) begin
      len_mem[row] <= len_q;
    end
    len_q <= len_mem[rd_row];
    vld_q <= len_vld[rd_row];
    chr_q <= chr_mem[chr_ra];
  end

endmodule
`default_nettype wire

>>> rtl/string_key_bucket_hash_table_top.sv
// Top level of the string-keyed bucket hash table.
// Depends on skh_pkg, skh_gather and skh_engine.
//
// Keys arrive one character per transfer; a transfer with last set runs
// insert, search or delete on the whole key and yields one result transfer.
// A final character starts a walk of one bucket that checks slot lengths and
// compares or copies characters through the slot memories, which have
// registered reads. The input is not ready while the walk runs. The table is
// empty after reset with no clearing pass.
`default_nettype none
module string_key_bucket_hash_table_top #(
  parameter int BUCKETS     = 33,
  parameter int SLOTS       = 6,
  parameter int MAX_KEY_LEN = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] action,
  input  wire logic [6:0] key_char,
  input  wire logic       last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      status,
  output logic [5:0]      bucket
);

  localparam int IW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;

  logic               accept;
  logic               start;
  logic               idle;
  skh_pkg::key_info_t info;
  logic [IW-1:0]      kb_ra;
  logic [6:0]         kb_q;

  // A final character waits until the result register is free.
  assign in_ready = idle && !(out_valid && last);
  assign accept   = in_valid && in_ready;

  skh_gather #(
    .BUCKETS    (BUCKETS),
    .MAX_KEY_LEN(MAX_KEY_LEN)
  ) u_gather (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .action  (action),
    .key_char(key_char),
    .last    (last),
    .kb_ra   (kb_ra),
    .kb_q    (kb_q),
    .start   (start),
    .info    (info)
  );

  skh_engine #(
    .BUCKETS    (BUCKETS),
    .SLOTS      (SLOTS),
    .MAX_KEY_LEN(MAX_KEY_LEN)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .start    (start),
    .info     (info),
    .kb_ra    (kb_ra),
    .kb_q     (kb_q),
    .idle     (idle),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .bucket   (bucket)
  );

endmodule
`default_nettype wire

>>> test/skh_checker.sv
// Checker for the string-keyed bucket hash table: watches the key and result
// channels, predicts each result with its own table model and compares them.
// Depends on skh_pkg for the action and status codes.
module skh_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] action,
  input  logic [6:0] key_char,
  input  logic       last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] status,
  input  logic [5:0] bucket,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB = 33;
  localparam int NS = 6;
  localparam int ML = 32;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] bucket;
  } table_result_t;

  logic [6:0] gather_chars [ML];
  int         gather_len;
  int         gather_sum;
  bit         gather_over;
  logic [6:0] stored_chars [NB][NS][ML];
  int         stored_len [NB][NS];
  bit         refuse_dups;
  table_result_t expected_results[$];

  function automatic int find_slot(int b);
    bit same;
    for (int s = 0; s < NS; s++) begin
      if (stored_len[b][s] != 0 && stored_len[b][s] == gather_len) begin
        same = 1;
        for (int i = 0; i < gather_len; i++)
          if (stored_chars[b][s][i] != gather_chars[i]) same = 0;
        if (same) return s;
      end
    end
    return NS;
  endfunction

  function automatic logic [2:0] run_key(logic [1:0] act, int b);
    int s;
    if (gather_over) return skh_pkg::ST_TOO_LONG;
    if (act == skh_pkg::ACT_INSERT) begin
      if (refuse_dups && find_slot(b) < NS) return skh_pkg::ST_DUPLICATE;
      for (s = 0; s < NS; s++)
        if (stored_len[b][s] == 0) begin
          for (int i = 0; i < gather_len; i++) stored_chars[b][s][i] = gather_chars[i];
          stored_len[b][s] = gather_len;
          return skh_pkg::ST_OK;
        end
      return skh_pkg::ST_FULL;
    end
    if (act == skh_pkg::ACT_DELETE) begin
      s = find_slot(b);
      if (s >= NS) return skh_pkg::ST_NOT_FOUND;
      for (; s + 1 < NS; s++) begin
        stored_chars[b][s] = stored_chars[b][s + 1];
        stored_len[b][s] = stored_len[b][s + 1];
      end
      stored_len[b][NS - 1] = 0;
      return skh_pkg::ST_OK;
    end
    return (find_slot(b) < NS) ? skh_pkg::ST_OK : skh_pkg::ST_NOT_FOUND;
  endfunction

  always @(posedge clk) begin
    table_result_t r, want;
    if (rst) begin
      gather_len = 0;
      gather_sum = 0;
      gather_over = 0;
      refuse_dups = 0;
      for (int b = 0; b < NB; b++)
        for (int s = 0; s < NS; s++) stored_len[b][s] = 0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) refuse_dups = cfg_wdata;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d bucket=%0d", $time, status, bucket);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status || bucket !== want.bucket) begin
            $display("%0t: expected status=%0d bucket=%0d, actual status=%0d bucket=%0d",
                     $time, want.status, want.bucket, status, bucket);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (!gather_over && gather_len < ML) begin
          gather_chars[gather_len] = key_char;
          gather_len++;
        end else begin
          gather_over = 1;
        end
        gather_sum = (gather_sum + key_char) % NB;
        if (last) begin
          r.bucket = gather_sum[5:0];
          r.status = run_key(action, gather_sum);
          expected_results.push_back(r);
          gather_len = 0;
          gather_sum = 0;
          gather_over = 0;
        end
      end
    end
    pending = expected_results.size();
  end
endmodule

>>> test/tb_string_key_bucket_hash_table_top.sv
// Testbench top for the string-keyed bucket hash table: drives keys and the
// duplicate-reject register, stalls the result side, and gives the verdict.
// Depends on skh_pkg, skh_checker and the block's RTL.
module tb_string_key_bucket_hash_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 0;
  logic       rst = 1;
  logic       cfg_we = 0;
  logic       cfg_wdata = 0;
  logic       in_valid = 0;
  logic       in_ready;
  logic [1:0] action = skh_pkg::ACT_INSERT;
  logic [6:0] key_char = 7'd1;
  logic       last = 0;
  logic       out_valid;
  logic       out_ready = 0;
  logic [2:0] status;
  logic [5:0] bucket;
  int         fail_count;
  int         pending;
  bit         calm = 0;
  int         keys_sent = 0;

  // Small key pool so searches, deletes and duplicates actually hit.
  logic [6:0] pool_chars [16][40];
  int         pool_len [16];

  always #2 clk = ~clk;

  string_key_bucket_hash_table_top u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .key_char(key_char), .last(last), .out_valid(out_valid),
    .out_ready(out_ready), .status(status), .bucket(bucket)
  );

  skh_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .key_char(key_char), .last(last), .out_valid(out_valid),
    .out_ready(out_ready), .status(status), .bucket(bucket),
    .fail_count(fail_count), .pending(pending)
  );

  always @(negedge clk) out_ready <= calm || ($urandom_range(99) >= 24);

  // One character transfer, with a random idle gap in front of it. Valid
  // stays high after the transfer so that back-to-back characters follow
  // without a gap; idling and draining drop it.
  task automatic send_char(logic [1:0] act, logic [6:0] ch, logic lst);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    action <= act;
    key_char <= ch;
    last <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_pool_key(logic [1:0] act, int k);
    for (int i = 0; i < pool_len[k]; i++)
      send_char(($urandom_range(1) ? act : 2'($urandom)), pool_chars[k][i],
                i == pool_len[k] - 1);
    keys_sent++;
  endtask

  task automatic drain(int extra);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reject(logic v);
    drain(500);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int k;
    int n;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    for (int p = 0; p < 16; p++) begin
      pool_len[p] = (p == 0) ? 1 : (p == 1) ? 32 : (p == 2) ? 33 : (p == 3) ? 40
                  : $urandom_range(1, 6);
      for (int i = 0; i < 40; i++)
        pool_chars[p][i] = (p == 1) ? 7'd127 : (p == 0) ? 7'd1 : 7'($urandom_range(0, 127));
    end
    // Seven keys of one bucket: six fill it, the seventh finds it full.
    for (int p = 4; p < 11; p++) begin
      pool_len[p] = 2;
      pool_chars[p][0] = 7'(p);
      pool_chars[p][1] = 7'(33 - p);
    end
    pool_chars[10][0] = 7'd0;
    pool_chars[10][1] = 7'd33;

    // Directed: extremes, each operation, full bucket, delete of a missing key.
    for (int p = 0; p < 11; p++) begin
      for (int i = 0; i < pool_len[p]; i++)
        send_char(skh_pkg::ACT_INSERT, pool_chars[p][i], i == pool_len[p] - 1);
    end
    for (int i = 0; i < 2; i++) send_char(2'd3, pool_chars[5][i], i == 1);
    for (int i = 0; i < 2; i++) send_char(skh_pkg::ACT_DELETE, pool_chars[5][i], i == 1);
    for (int i = 0; i < 2; i++) send_char(skh_pkg::ACT_DELETE, pool_chars[5][i], i == 1);
    for (int i = 0; i < 2; i++) send_char(skh_pkg::ACT_SEARCH, pool_chars[4][i], i == 1);
    write_reject(1);
    send_char(skh_pkg::ACT_INSERT, 7'd1, 1);
    send_char(skh_pkg::ACT_INSERT, 7'd1, 1);

    // Random keys, mostly from the pool; the register gets a random value between phases.
    while (keys_sent < 110) begin
      if (keys_sent % 25 == 24) write_reject(1'($urandom));
      calm = (keys_sent >= 40 && keys_sent < 70);
      k = $urandom_range(15);
      if ($urandom_range(9) < 7) begin
        send_pool_key(2'($urandom_range(2)), k);
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          send_char(2'($urandom), 7'($urandom_range(0, 127)), i == n - 1);
        keys_sent++;
      end
    end
    write_reject(0);
    drain(2000);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
